FILE: rtl/tps_pkg.sv
// shared types for the triangle plane slicer
// no dependencies; used by tps_interp and triangle_plane_slice
`default_nettype none

package tps_pkg;

   // tag that rides along the interpolation pipeline
   typedef struct packed {
      logic valid;
      logic hit;
   } tag_type;

   // triangle edges in test order
   typedef enum logic [1:0] {
      EDGE_01 = 2'd0,
      EDGE_12 = 2'd1,
      EDGE_20 = 2'd2
   } edge_type;

   localparam int unsigned NUM_VERTS = 3;

endpackage

`default_nettype wire

FILE: rtl/triangle_plane_slice.sv
// triangle plane slicer top level: edge selection, four interpolation lanes, output register
// depends on tps_pkg and tps_interp
//
//   channel | direction | tdata (low bit up)                            | tuser
//   req_    | in        | v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z plane_z | -
//   rsp_    | out       | start_x start_y end_x end_y                   | hit
//
// one transaction enters per cycle unless rsp_ stalls; quotient stages resolve one bit each
// synchronous reset clears all valid bits; no clearing pass
// a stalled rsp_ freezes the whole pipeline; req_tready follows the output register
`default_nettype none

module triangle_plane_slice #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, plane_z
   input  wire logic [((10*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // start_x, start_y, end_x, end_y
   output logic      [((4*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // hit
   output logic      [0:0]                             rsp_tuser
);

   localparam int W      = COORD_WIDTH;
   localparam int OUT_TW = ((4 * W + 7) / 8) * 8;

   logic en;

   // input stage
   logic              a_valid_ff;
   logic [10*W-1:0]   a_data_ff;

   logic signed [W-1:0] vx [tps_pkg::NUM_VERTS];
   logic signed [W-1:0] vy [tps_pkg::NUM_VERTS];
   logic signed [W-1:0] vz [tps_pkg::NUM_VERTS];
   logic signed [W-1:0] pz;
   logic [2:0]          crossing;
   logic                hit;
   tps_pkg::edge_type   ea, eb;
   tps_pkg::tag_type    tag_a;

   logic [W-1:0] ci [4];
   logic [W-1:0] cj [4];
   logic [W-1:0] zi [4];
   logic [W-1:0] zj [4];
   logic [W-1:0] res [4];
   tps_pkg::tag_type tag_o [4];

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [4*W-1:0]    rsp_data_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
      if (en) begin
         a_data_ff <= req_tdata[10*W-1:0];
      end
   end

   always_comb begin
      for (int v = 0; v < tps_pkg::NUM_VERTS; v++) begin
         vx[v] = a_data_ff[(3*v)*W +: W];
         vy[v] = a_data_ff[(3*v+1)*W +: W];
         vz[v] = a_data_ff[(3*v+2)*W +: W];
      end
      pz = a_data_ff[9*W +: W];
   end

   function automatic logic crosses(input logic signed [W-1:0] za,
                                    input logic signed [W-1:0] zb,
                                    input logic signed [W-1:0] p);
      logic signed [W-1:0] lo, hi;
      lo = (za < zb) ? za : zb;
      hi = (za > zb) ? za : zb;
      return (lo <= p) && (hi > p);
   endfunction

   always_comb begin
      crossing[0] = crosses(vz[0], vz[1], pz);
      crossing[1] = crosses(vz[1], vz[2], pz);
      crossing[2] = crosses(vz[2], vz[0], pz);
      // strict straddle: some vertex below and some vertex above
      hit = ((vz[0] < pz) || (vz[1] < pz) || (vz[2] < pz)) &&
            ((vz[0] > pz) || (vz[1] > pz) || (vz[2] > pz));
      ea  = crossing[0] ? tps_pkg::EDGE_01 :
            (crossing[1] ? tps_pkg::EDGE_12 : tps_pkg::EDGE_20);
      eb  = (crossing[0] && crossing[1]) ? tps_pkg::EDGE_12 : tps_pkg::EDGE_20;
      tag_a.valid = a_valid_ff;
      tag_a.hit   = hit;
   end

   function automatic logic [1:0] vert_i(input tps_pkg::edge_type e);
      case (e)
         tps_pkg::EDGE_01: return 2'd0;
         tps_pkg::EDGE_12: return 2'd1;
         default:          return 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] vert_j(input tps_pkg::edge_type e);
      case (e)
         tps_pkg::EDGE_01: return 2'd1;
         tps_pkg::EDGE_12: return 2'd2;
         default:          return 2'd0;
      endcase
   endfunction

   // lanes: start x, start y, end x, end y
   always_comb begin
      ci[0] = vx[vert_i(ea)];  cj[0] = vx[vert_j(ea)];
      ci[1] = vy[vert_i(ea)];  cj[1] = vy[vert_j(ea)];
      ci[2] = vx[vert_i(eb)];  cj[2] = vx[vert_j(eb)];
      ci[3] = vy[vert_i(eb)];  cj[3] = vy[vert_j(eb)];
      zi[0] = vz[vert_i(ea)];  zj[0] = vz[vert_j(ea)];
      zi[1] = zi[0];           zj[1] = zj[0];
      zi[2] = vz[vert_i(eb)];  zj[2] = vz[vert_j(eb)];
      zi[3] = zi[2];           zj[3] = zj[2];
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      tps_interp #(
         .COORD_WIDTH (W)
      ) u_interp (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .tag_in  (tag_a),
         .ci      (ci[l]),
         .cj      (cj[l]),
         .zi      (zi[l]),
         .zj      (zj[l]),
         .z       (pz),
         .tag_out (tag_o[l]),
         .res     (res[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tag_o[0].valid;
      end
      if (en) begin
         rsp_hit_ff  <= tag_o[0].hit;
         rsp_data_ff <= tag_o[0].hit ? {res[3], res[2], res[1], res[0]} : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_hit_ff;
   assign rsp_tdata    = OUT_TW'(rsp_data_ff);

   // a miss carries zero endpoints
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_data_ff == '0)
      else $error("miss transaction with nonzero endpoints");

   // a new result only appears from a valid pipeline slot
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_tvalid) |-> $past(tag_o[0].valid))
      else $error("result without a pipelined transaction");

   // the first and last lanes stay in step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      tag_o[0] == tag_o[3])
      else $error("interpolation lanes out of step");

endmodule

`default_nettype wire

FILE: rtl/tps_interp.sv
// one interpolation lane: c = ci + round((z - zi) * (cj - ci) / (zj - zi))
// difference stage, multiply stage, then one restoring quotient bit per stage
// depends on tps_pkg
`default_nettype none

module tps_interp #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire tps_pkg::tag_type       tag_in,
   input  wire logic [COORD_WIDTH-1:0] ci,
   input  wire logic [COORD_WIDTH-1:0] cj,
   input  wire logic [COORD_WIDTH-1:0] zi,
   input  wire logic [COORD_WIDTH-1:0] zj,
   input  wire logic [COORD_WIDTH-1:0] z,
   output tps_pkg::tag_type            tag_out,
   output logic      [COORD_WIDTH-1:0] res
);

   localparam int W = COORD_WIDTH;
   localparam int P = 2 * W + 2;

   // difference stage
   logic [W:0]   dn_in, dc_in, dd_in;
   logic [W:0]   mdn_ff, mdc_ff, md_ff;
   logic         neg_d_ff;
   logic [W-1:0] ci_d_ff;
   tps_pkg::tag_type tag_d_ff;

   // quotient stages, index 0 is the multiply output
   logic [W:0]   rem_ff  [0:W];
   logic [W-1:0] low_ff  [0:W];
   logic [W-1:0] quo_ff  [0:W];
   logic [W:0]   d_ff    [0:W];
   logic         neg_ff  [0:W];
   logic [W-1:0] ci_ff   [0:W];
   tps_pkg::tag_type tag_ff [0:W];

   logic [P-1:0] prod;
   logic [P-1:0] num;

   assign dn_in = {z[W-1], z} - {zi[W-1], zi};
   assign dc_in = {cj[W-1], cj} - {ci[W-1], ci};
   assign dd_in = {zj[W-1], zj} - {zi[W-1], zi};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff <= '0;
      end else if (en) begin
         tag_d_ff <= tag_in;
      end
      if (en) begin
         mdn_ff   <= dn_in[W] ? -dn_in : dn_in;
         mdc_ff   <= dc_in[W] ? -dc_in : dc_in;
         md_ff    <= dd_in[W] ? -dd_in : dd_in;
         neg_d_ff <= dn_in[W] ^ dc_in[W] ^ dd_in[W];
         ci_d_ff  <= ci;
      end
   end

   // rounding: add half the divisor before truncating
   assign prod = mdn_ff * mdc_ff;
   assign num  = prod + P'(md_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (en) begin
         tag_ff[0] <= tag_d_ff;
      end
      if (en) begin
         // quotient fits in W bits, so the upper part is already below the divisor
         rem_ff[0] <= num[P-2:W];
         low_ff[0] <= num[W-1:0];
         quo_ff[0] <= '0;
         d_ff[0]   <= md_ff;
         neg_ff[0] <= neg_d_ff;
         ci_ff[0]  <= ci_d_ff;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_div
      logic [W+1:0] trial;
      logic [W+1:0] diff;
      logic         ge;

      assign trial = {rem_ff[k], low_ff[k][W-1]};
      assign diff  = trial - {1'b0, d_ff[k]};
      assign ge    = trial >= {1'b0, d_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else if (en) begin
            tag_ff[k+1] <= tag_ff[k];
         end
         if (en) begin
            rem_ff[k+1] <= ge ? diff[W:0] : trial[W:0];
            low_ff[k+1] <= {low_ff[k][W-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][W-2:0], ge};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ci_ff[k+1]  <= ci_ff[k];
         end
      end
   end

   assign res     = neg_ff[W] ? (ci_ff[W] - quo_ff[W]) : (ci_ff[W] + quo_ff[W]);
   assign tag_out = tag_ff[W];

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for triangle_plane_slice: streams triangles, predicts each segment and checks it
// depends on tps_pkg and triangle_plane_slice
`default_nettype none

module tb;

   localparam int CW = 32;
   localparam int IN_W = 10 * CW;
   localparam int OUT_W = 4 * CW;
   localparam int LATENCY = CW + 4;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct {
      logic        hit;
      logic [31:0] sx, sy, ex, ey;
   } segment_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata = '0;   // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z plane_z
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [OUT_W-1:0]  rsp_tdata;        // start_x start_y end_x end_y
   logic [0:0]        rsp_tuser;        // hit

   segment_type segments_due[$];
   int  failures = 0;
   int  sent = 0, hits = 0, received = 0;
   int  send_idle_pct = 0, stall_pct = 0;
   int  hold_cycles = 0;
   longint cycle_count = 0;

   triangle_plane_slice #(.COORD_WIDTH(CW)) DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // exact rounded interpolation, ties away from zero
   function automatic longint cross_coord(longint ci, longint cj, longint zi, longint zj,
                                          longint z);
      logic signed [127:0] num, den, q;
      logic               neg;
      if (zj == zi || z == zi || cj == ci) return ci;
      num = 128'(z - zi) * 128'(cj - ci);
      den = 128'(zj - zi);
      neg = (num < 0) != (den < 0);
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = (num + (den >>> 1)) / den;
      return neg ? ci - longint'(q) : ci + longint'(q);
   endfunction

   function automatic segment_type slice_triangle(logic [IN_W-1:0] d);
      segment_type s;
      longint    x[3], y[3], zz[3], pz, zmin, zmax, lo, hi;
      longint    px[2], py[2];
      int        n, j;
      for (int i = 0; i < 3; i++) begin
         x[i] = longint'($signed(d[(3*i)*CW +: CW]));
         y[i] = longint'($signed(d[(3*i+1)*CW +: CW]));
         zz[i] = longint'($signed(d[(3*i+2)*CW +: CW]));
      end
      pz = longint'($signed(d[9*CW +: CW]));
      s = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
      px = '{0, 0};
      py = '{0, 0};
      n = 0;
      zmin = zz[0];
      zmax = zz[0];
      for (int i = 1; i < 3; i++) begin
         if (zz[i] < zmin) zmin = zz[i];
         if (zz[i] > zmax) zmax = zz[i];
      end
      if (!(zmin < pz && pz < zmax)) return s;
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         lo = zz[i] < zz[j] ? zz[i] : zz[j];
         hi = zz[i] > zz[j] ? zz[i] : zz[j];
         if (lo <= pz && hi > pz && n < 2) begin
            px[n] = cross_coord(x[i], x[j], zz[i], zz[j], pz);
            py[n] = cross_coord(y[i], y[j], zz[i], zz[j], pz);
            n++;
         end
      end
      s.hit = 1'b1;
      s.sx = px[0][31:0];
      s.sy = py[0][31:0];
      s.ex = px[1][31:0];
      s.ey = py[1][31:0];
      return s;
   endfunction

   // receiver: random stalls plus a counted long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      segment_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (segments_due.size() == 0) begin
            $error("segment with no triangle outstanding");
            failures++;
         end else begin
            e = segments_due.pop_front();
            if (rsp_tuser[0] !== e.hit) begin
               $error("hit: expected %0d, got %0d", e.hit, rsp_tuser[0]);
               failures++;
            end
            if (rsp_tdata[31:0] !== e.sx) begin
               $error("start_x: expected %h, got %h", e.sx, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[63:32] !== e.sy) begin
               $error("start_y: expected %h, got %h", e.sy, rsp_tdata[63:32]);
               failures++;
            end
            if (rsp_tdata[95:64] !== e.ex) begin
               $error("end_x: expected %h, got %h", e.ex, rsp_tdata[95:64]);
               failures++;
            end
            if (rsp_tdata[127:96] !== e.ey) begin
               $error("end_y: expected %h, got %h", e.ey, rsp_tdata[127:96]);
               failures++;
            end
         end
      end
   end

   task automatic send_triangle(logic [31:0] c[10]);
      logic [IN_W-1:0] d;
      segment_type     s;
      for (int i = 0; i < 10; i++) d[i*CW +: CW] = c[i];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      s = slice_triangle(d);
      do @(posedge clock); while (!req_tready);
      segments_due = {segments_due, s};
      sent++;
      if (s.hit) hits++;
   endtask

   // vertices ordered x,y,z per vertex, then plane height
   task automatic send_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                           int x2, int y2, int z2, int p);
      logic [31:0] c[10];
      c = '{x0, y0, z0, x1, y1, z1, x2, y2, z2, p};
      send_triangle(c);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 131072, 32768);
      send_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 131072, 0);        // plane at min vertex
      send_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 131072, 131072);   // plane at max vertex
      send_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 131072, 65536);    // through middle vertex
      send_tri(1, 2, 5, 3, 4, 5, 5, 6, 5, 5);                         // flat triangle
      send_tri(0, 0, 0, 10, 10, 10, 20, 20, 10, 5);                   // edge lies above plane
      send_tri(0, 0, 0, 10, 10, 0, 20, 20, 10, 5);                    // flat edge at bottom
      send_tri(0, 0, 0, 10, 10, 10, 20, 20, 0, 20);                   // plane above all
      send_tri(0, 0, 0, 1, 1, 2, 3, 3, 2, 1);                         // rounding tie
      send_tri(0, 0, 0, -1, -1, 2, -3, -3, 2, 1);                     // negative tie
      send_tri(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
      send_tri(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000001);
      send_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 0, 0, 0, 32'h7ffffffe);
      send_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      wait_drained();
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                     : 32'h80000000 + $urandom_range(3);
         default: return 32'($signed($urandom_range(4000)) - 2000) <<< $urandom_range(16);
      endcase
   endfunction

   task automatic test_random(int count);
      logic [31:0] c[10];
      int          zsel, a, b;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 10; i++) c[i] = rand_coord();
         zsel = $urandom_range(9);
         if (zsel < 7) begin
            // mostly straddling: plane strictly between two vertex heights
            a = $signed(c[2]);
            b = $signed(c[5]);
            if (a > b) begin a = b; b = $signed(c[2]); end
            if (longint'(b) - longint'(a) >= 2)
               c[9] = 32'(longint'(a) + 1 + longint'($urandom()) % (longint'(b) - a - 1));
            if (zsel == 0) c[8] = c[9];    // vertex on the plane
         end else if (zsel == 7) begin
            c[9] = c[$urandom_range(2) * 3 + 2];
         end
         send_triangle(c);
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      stall_pct = 0;
      send_idle_pct = 0;
      test_random(150);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400);
      send_idle_pct = 80;
      test_random(300);
      send_idle_pct = 0;
      stall_pct = 80;
      test_random(300);
      send_idle_pct = 14;
      stall_pct = 14;
      test_random(350);
      stall_pct = 0;
      send_idle_pct = 0;
      wait_drained();
      test_backpressure();
      test_random(200);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d triangles, %0d of them hit, %0d segments checked",
               sent, hits, received);
      $display("phases: free flow, sparse sender, stalled receiver, mixed, long hold-off");
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
